@@ rtl/core/u8u16p_pkg.sv @@
`default_nettype none
//------------------------------------------------------------------------------
// u8u16p_pkg
// Shared types and constants of the UTF-8 decoder with UTF-16 positions.
//------------------------------------------------------------------------------
package u8u16p_pkg;

  localparam int DEF_LINE_BITS   = 24;
  localparam int DEF_COLUMN_BITS = 24;
  localparam int DEF_OFFSET_BITS = 32;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam int CP_W        = 21;
  localparam int LINE_W      = 24;
  localparam int COLUMN_W    = 24;
  localparam int OFFSET_W    = 32;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00fffd;
  localparam logic [CP_W-1:0] BMP_MAX     = 21'h00ffff;
  localparam logic [CP_W-1:0] CP_LF       = 21'h00000a;
  localparam logic [CP_W-1:0] CP_CR       = 21'h00000d;

  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] LEAD2_LO  = 8'hc2;
  localparam logic [7:0] LEAD2_HI  = 8'hdf;
  localparam logic [7:0] LEAD3_LO  = 8'he0;
  localparam logic [7:0] LEAD3_HI  = 8'hef;
  localparam logic [7:0] LEAD4_LO  = 8'hf0;
  localparam logic [7:0] LEAD4_HI  = 8'hf4;
  localparam logic [7:0] LEAD_ED   = 8'hed;
  localparam logic [7:0] CONT_A0   = 8'ha0;
  localparam logic [7:0] CONT_90   = 8'h90;
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam logic [2:0] LEN2 = 3'd2;
  localparam logic [2:0] LEN3 = 3'd3;
  localparam logic [2:0] LEN4 = 3'd4;

  // Everything one input byte causes, in emission order.
  typedef struct packed {
    logic            cr_first;
    logic            cr_brk;
    logic [1:0]      flush1_n;
    logic            main_v;
    logic [CP_W-1:0] main_cp;
    logic [2:0]      main_bytes;
    logic            main_bad;
    logic            main_brk;
    logic            cr_last;
    logic [1:0]      flush2_n;
    logic            eot;
  } rec_t;

  typedef struct packed {
    logic       held_cr;
    logic [1:0] pend_cnt;
  } front_status_t;

  typedef struct packed {
    logic [CP_W-1:0]     cp;
    logic [2:0]          bytes;
    logic [1:0]          units;
    logic                bad;
    logic                brk;
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] col;
    logic [OFFSET_W-1:0] off;
    logic                last_result;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/u8u16p_front.sv @@
`default_nettype none
//------------------------------------------------------------------------------
// u8u16p_front
// Accepts bytes, validates UTF-8 sequences and builds one request record.
//------------------------------------------------------------------------------
module u8u16p_front
  import u8u16p_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_eot,
  output      logic          rec_valid,
  input  wire logic          rec_ready,
  output      rec_t          rec,
  output      front_status_t status
);

  logic       held_cr;
  logic [1:0] pend_cnt;
  logic [2:0] exp_len;
  logic [7:0] pend0, pend1, pend2;

  logic            held_cr_next;
  logic [1:0]      pend_cnt_next;
  logic [2:0]      exp_len_next;
  logic            fit;
  logic            used;
  logic            start_lead;
  logic            store;
  logic [CP_W-1:0] cp_full;
  logic            accept;

  assign in_ready  = rec_ready;
  assign rec_valid = in_valid;
  assign accept    = in_valid && rec_ready;
  assign status    = '{held_cr: held_cr, pend_cnt: pend_cnt};

  always_comb begin
    fit = ((in_byte & CONT_MASK) == CONT_TAG);
    if (pend_cnt == 2'd1) begin
      if (pend0 == LEAD3_LO && in_byte < CONT_A0) fit = 1'b0;
      if (pend0 == LEAD_ED && in_byte >= CONT_A0) fit = 1'b0;
      if (pend0 == LEAD4_LO && in_byte < CONT_90) fit = 1'b0;
      if (pend0 == LEAD4_HI && in_byte >= CONT_90) fit = 1'b0;
    end
  end

  always_comb begin
    unique case (exp_len)
      LEN2:    cp_full = {10'd0, pend0[4:0], in_byte[5:0]};
      LEN3:    cp_full = {5'd0, pend0[3:0], pend1[5:0], in_byte[5:0]};
      default: cp_full = {pend0[2:0], pend1[5:0], pend2[5:0], in_byte[5:0]};
    endcase
  end

  always_comb begin
    rec           = '0;
    held_cr_next  = 1'b0;
    pend_cnt_next = pend_cnt;
    exp_len_next  = exp_len;
    used          = 1'b0;
    start_lead    = 1'b0;
    store         = 1'b0;

    rec.cr_first = held_cr;
    rec.cr_brk   = (in_byte == CH_LF);

    if (pend_cnt != 2'd0) begin
      if (fit) begin
        used = 1'b1;
        if (({1'b0, pend_cnt} + 3'd1) >= exp_len) begin
          rec.main_v     = 1'b1;
          rec.main_cp    = cp_full;
          rec.main_bytes = exp_len;
          pend_cnt_next  = 2'd0;
          exp_len_next   = 3'd0;
        end else begin
          store         = 1'b1;
          pend_cnt_next = pend_cnt + 2'd1;
        end
      end else begin
        rec.flush1_n  = pend_cnt;
        pend_cnt_next = 2'd0;
        exp_len_next  = 3'd0;
      end
    end

    if (!used) begin
      if (!in_byte[7]) begin
        if (in_byte == CH_CR) begin
          held_cr_next = 1'b1;
        end else begin
          rec.main_v     = 1'b1;
          rec.main_cp    = {13'd0, in_byte};
          rec.main_bytes = 3'd1;
          rec.main_brk   = (in_byte == CH_LF);
        end
      end else if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI) begin
        exp_len_next  = LEN2;
        pend_cnt_next = 2'd1;
        start_lead    = 1'b1;
      end else if (in_byte >= LEAD3_LO && in_byte <= LEAD3_HI) begin
        exp_len_next  = LEN3;
        pend_cnt_next = 2'd1;
        start_lead    = 1'b1;
      end else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI) begin
        exp_len_next  = LEN4;
        pend_cnt_next = 2'd1;
        start_lead    = 1'b1;
      end else begin
        rec.main_v     = 1'b1;
        rec.main_cp    = REPLACEMENT;
        rec.main_bytes = 3'd1;
        rec.main_bad   = 1'b1;
      end
    end

    if (in_eot) begin
      rec.cr_last   = held_cr_next;
      rec.flush2_n  = pend_cnt_next;
      rec.eot       = 1'b1;
      held_cr_next  = 1'b0;
      pend_cnt_next = 2'd0;
      exp_len_next  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cr  <= 1'b0;
      pend_cnt <= 2'd0;
      exp_len  <= 3'd0;
    end else if (accept) begin
      held_cr  <= held_cr_next;
      pend_cnt <= pend_cnt_next;
      exp_len  <= exp_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && start_lead) pend0 <= in_byte;
    if (accept && store && pend_cnt == 2'd1) pend1 <= in_byte;
    if (accept && store && pend_cnt == 2'd2) pend2 <= in_byte;
  end

endmodule
`default_nettype wire

@@ rtl/core/u8u16p_fifo.sv @@
`default_nettype none
//------------------------------------------------------------------------------
// u8u16p_fifo
// Short request queue between the decoder front and the result sequencer.
//------------------------------------------------------------------------------
module u8u16p_fifo
  import u8u16p_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output      logic wr_ready,
  input  wire rec_t wr_data,
  output      logic rd_valid,
  input  wire logic rd_ready,
  output      rec_t rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             push;
  logic             pop;

  assign wr_ready = (cnt != CNT_W'(DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop) begin
        cnt <= cnt + CNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule
`default_nettype wire

@@ rtl/core/u8u16p_back.sv @@
`default_nettype none
//------------------------------------------------------------------------------
// u8u16p_back
// Steps through the results of each request and tracks line, column and offset.
//------------------------------------------------------------------------------
module u8u16p_back
  import u8u16p_pkg::*;
#(
  parameter int LINE_BITS   = DEF_LINE_BITS,
  parameter int COLUMN_BITS = DEF_COLUMN_BITS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    rec_valid,
  output      logic    rec_ready,
  input  wire rec_t    rec,
  output      logic    out_valid,
  input  wire logic    out_ready,
  output      result_t res
);

  logic [2:0]             evt;
  logic [LINE_BITS-1:0]   line_cnt;
  logic [COLUMN_BITS-1:0] col_cnt;
  logic [OFFSET_BITS-1:0] off_cnt;

  logic [2:0]             n_ev;
  logic [2:0]             t1;
  logic [CP_W-1:0]        ev_cp;
  logic [2:0]             ev_bytes;
  logic                   ev_bad;
  logic                   ev_brk;
  logic [1:0]             ev_units;
  logic                   visible;
  logic                   step;
  logic                   done;
  logic [LINE_BITS:0]     line_sum;
  logic [COLUMN_BITS:0]   col_sum;
  logic [OFFSET_BITS:0]   off_sum;
  logic [LINE_BITS-1:0]   line_cnt_next;
  logic [COLUMN_BITS-1:0] col_cnt_next;
  logic [OFFSET_BITS-1:0] off_cnt_next;

  assign n_ev = {2'd0, rec.cr_first} + {1'b0, rec.flush1_n} + {2'd0, rec.main_v}
              + {2'd0, rec.cr_last} + {1'b0, rec.flush2_n};
  assign t1   = {2'd0, rec.cr_first} + {1'b0, rec.flush1_n};

  always_comb begin
    ev_cp    = REPLACEMENT;
    ev_bytes = 3'd1;
    ev_bad   = 1'b1;
    ev_brk   = 1'b0;
    priority if (rec.cr_first && evt == 3'd0) begin
      ev_cp  = CP_CR;
      ev_bad = 1'b0;
      ev_brk = rec.cr_brk;
    end else if (evt < t1) begin
      ev_cp = REPLACEMENT;
    end else if (rec.main_v && evt == t1) begin
      ev_cp    = rec.main_cp;
      ev_bytes = rec.main_bytes;
      ev_bad   = rec.main_bad;
      ev_brk   = rec.main_brk;
    end else if (rec.cr_last && evt == t1) begin
      ev_cp  = CP_CR;
      ev_bad = 1'b0;
    end else begin
      ev_cp = REPLACEMENT;
    end
  end

  assign ev_units  = (ev_cp > BMP_MAX) ? 2'd2 : 2'd1;
  assign visible   = !evt[2];
  assign step      = rec_valid && (n_ev == 3'd0 || !visible || !out_valid || out_ready);
  assign done      = (n_ev == 3'd0) || (evt == n_ev - 3'd1);
  assign rec_ready = step && done;

  assign line_sum = {1'b0, line_cnt} + (LINE_BITS + 1)'(1);
  assign col_sum  = {1'b0, col_cnt} + (COLUMN_BITS + 1)'(ev_units);
  assign off_sum  = {1'b0, off_cnt} + (OFFSET_BITS + 1)'(ev_bytes);

  always_comb begin
    off_cnt_next  = off_sum[OFFSET_BITS] ? '1 : off_sum[OFFSET_BITS-1:0];
    col_cnt_next  = col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];
    line_cnt_next = line_cnt;
    if (ev_cp == CP_LF) begin
      line_cnt_next = line_sum[LINE_BITS] ? '1 : line_sum[LINE_BITS-1:0];
      col_cnt_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evt       <= 3'd0;
      line_cnt  <= '0;
      col_cnt   <= '0;
      off_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        evt <= done ? 3'd0 : evt + 3'd1;
        if (done && rec.eot) begin
          line_cnt <= '0;
          col_cnt  <= '0;
          off_cnt  <= '0;
        end else if (n_ev != 3'd0) begin
          line_cnt <= line_cnt_next;
          col_cnt  <= col_cnt_next;
          off_cnt  <= off_cnt_next;
        end
      end
      if (step && n_ev != 3'd0 && visible) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && n_ev != 3'd0 && visible) begin
      res.cp          <= ev_cp;
      res.bytes       <= ev_bytes;
      res.units       <= ev_units;
      res.bad         <= ev_bad;
      res.brk         <= ev_brk;
      res.line        <= LINE_W'(line_cnt);
      res.col         <= COLUMN_W'(col_cnt);
      res.off         <= OFFSET_W'(off_cnt);
      res.last_result <= rec.eot && (done || evt == 3'd3);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/utf8_decode_utf16_position_unit.sv @@
`default_nettype none
//------------------------------------------------------------------------------
// utf8_decode_utf16_position_unit
// Strict UTF-8 decoder reporting each scalar with its UTF-16 position.
//------------------------------------------------------------------------------
// The unit takes one document byte per cycle while the request queue has
// room. Each byte's request is written into the queue, and the result
// sequencer then emits its results one at a time into the output register:
// at most four when a broken four-byte sequence is flushed ahead of the byte
// that broke it, and a request may also yield none; a queue of QUEUE_DEPTH
// requests lets input continue while such a burst drains. Line, column and
// offset counters saturate, and an end-of-text byte returns all state to its
// reset value after its last result.
//------------------------------------------------------------------------------
module utf8_decode_utf16_position_unit
  import u8u16p_pkg::*;
#(
  parameter int LINE_BITS   = DEF_LINE_BITS,
  parameter int COLUMN_BITS = DEF_COLUMN_BITS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // Fields from bit 0: data_byte.
  input  wire logic [7:0]             s_axis_tdata,
  input  wire logic                   s_axis_tlast,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // Fields from bit 0: code_point, byte_count, utf16_units, line_number,
  // utf16_column, byte_offset, zero fill.
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: malformed, line_break.
  output      logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output      logic                   m_axis_tlast
);

  rec_t          front_rec;
  logic          front_valid;
  logic          front_ready;
  rec_t          queue_rec;
  logic          queue_valid;
  logic          queue_ready;
  result_t       res;
  front_status_t front_status;

  u8u16p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_eot    (s_axis_tlast),
    .rec_valid (front_valid),
    .rec_ready (front_ready),
    .rec       (front_rec),
    .status    (front_status)
  );

  u8u16p_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_rec),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_data  (queue_rec)
  );

  u8u16p_back #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (queue_valid),
    .rec_ready (queue_ready),
    .rec       (queue_rec),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {6'd0, res.off, res.col, res.line, res.units, res.bytes, res.cp};
  assign m_axis_tuser = {res.brk, res.bad};
  assign m_axis_tlast = res.last_result;

  a_eot_clears_front: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=>
      (front_status.pend_cnt == 2'd0 && !front_status.held_cr))
    else $error("decoder state not cleared after end of text");

  a_repl_shape: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.bad) |->
      (res.cp == REPLACEMENT && res.bytes == 3'd1 && !res.brk))
    else $error("malformed result is not a one-byte replacement");

  a_units_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((res.cp > BMP_MAX) == (res.units == 2'd2)))
    else $error("UTF-16 unit count does not match code point");

endmodule
`default_nettype wire
